// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks on clk, switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression or property that holds at every edge
`define AST_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sfas_pkg.sv =====
// ----------------------------------------------------------------------------
// sfas_pkg
// operation codes, register indexes and result type of the sprite sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sfas_pkg;

  localparam int FRAME_IDX_W = 8;
  localparam int CFG_IDX_W   = 3;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_NEEDED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PAUSE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY    = 3'd7;

  // minus one in the 9 bit signed registers: full sheet, play forever
  localparam logic [8:0] NEG_ONE9 = 9'h1FF;

  typedef struct packed {
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   running;
    logic                   animation_end;
    logic                   cycle_end;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/sprite_frame_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_animation_sequencer
// pipeline: an input beat passes the input register, then the result register;
//   one beat per cycle sustained while m_tready is high, set by the single
//   stage that reads and writes the frame state between the two registers
// reset: rst is synchronous; it clears the frame state and both stages and
//   loads the register defaults (one frame, full sheet, play forever)
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_animation_sequencer #(
  parameter int  FRAMES_MAX = 256,
  parameter int  TIME_BITS  = 24,
  localparam int CFG_W      = (TIME_BITS > 9) ? TIME_BITS : 9,
  localparam int IN_W       = ((TIME_BITS + 8) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [IN_W-1:0]              s_tdata,   // delta_time, visible
  input  wire logic [1:0]                   s_tuser,   // operation
  // result stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [15:0]                       m_tdata,   // frame_index, running, cycle_end
  output logic                              m_tlast,   // animation_end
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic [sfas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data
);
  import sfas_pkg::*;

  localparam int FW     = $clog2(FRAMES_MAX);
  localparam int SW     = (FW + 2 > 11) ? FW + 2 : 11;
  localparam int FMAX_C = (FRAMES_MAX > 511) ? 511 : FRAMES_MAX;
  localparam logic [8:0] FMAX9 = 9'(FMAX_C);

  // configuration registers
  logic [TIME_BITS-1:0] frame_period, cycle_pause, start_delay;
  logic [8:0]           frame_count;
  logic signed [8:0]    range_first, range_last, repeat_init;
  logic                 reverse_needed;

  // frame state
  logic [FW-1:0]        current_frame, current_frame_next;
  logic                 active, active_next;
  logic                 reverse_pending, reverse_pending_next;
  logic                 reversing, reversing_next;
  logic signed [8:0]    repeats_left, repeats_left_next;
  logic signed [8:0]    range_offset, range_offset_next;
  logic [TIME_BITS-1:0] period_elapsed, period_elapsed_next;
  logic [TIME_BITS-1:0] pause_elapsed, pause_elapsed_next;
  logic signed [TIME_BITS:0] delay_left, delay_left_next;

  // input register and result register
  logic                 in_valid;
  logic [1:0]           in_op;
  logic [TIME_BITS-1:0] in_dt;
  logic                 in_vis;
  logic                 out_valid;
  result_t              res;
  logic                 advance;

  // combinational working values
  logic                 sheet;
  logic [8:0]           eff_count, last_frame;
  logic signed [SW-1:0] cur_w, rf_w, rl_w, ro_w, one_w, dir_w, dir_c_w, back_w;
  logic signed [SW-1:0] fa_w;
  logic [FW-1:0]        frame_fwd;
  logic [8:0]           dir9, dir_c9;
  logic                 cur_is_last, rep_pos, in_range;
  logic signed [8:0]    rep_dec;
  logic [TIME_BITS:0]   period_sum, pause_sum;
  logic                 end_flag, cyc_flag, hold;
  logic [FW+7:0]        frame_wide;

  function automatic logic [FW-1:0] place(input logic signed [SW-1:0] v,
                                          input logic [8:0] cnt);
    logic signed [SW-1:0] c;
    c = $signed({{(SW-9){1'b0}}, cnt});
    if (!v[SW-1] && (v < c)) begin
      return v[FW-1:0];
    end
    return '0;
  endfunction

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign sheet = (range_first == NEG_ONE9) && (range_last == NEG_ONE9);

  always_comb begin
    if (frame_count == 9'd0) begin
      eff_count = 9'd1;
    end else if (frame_count > FMAX9) begin
      eff_count = FMAX9;
    end else begin
      eff_count = frame_count;
    end
  end

  assign last_frame = eff_count - 9'd1;
  assign cur_w      = $signed({{(SW-FW){1'b0}}, current_frame});
  assign rf_w       = $signed({{(SW-9){range_first[8]}}, range_first});
  assign rl_w       = $signed({{(SW-9){range_last[8]}}, range_last});
  assign ro_w       = $signed({{(SW-9){range_offset[8]}}, range_offset});
  assign one_w      = $signed(SW'(1));
  assign dir_w      = reversing ? -one_w : one_w;
  assign dir_c_w    = reversing ? one_w : -one_w;
  assign dir9       = reversing ? 9'h1FF : 9'h001;
  assign dir_c9     = reversing ? 9'h001 : 9'h1FF;
  assign back_w     = (current_frame > FW'(1)) ? cur_w - one_w : '0;
  assign cur_is_last = (cur_w == $signed({{(SW-9){1'b0}}, last_frame}));
  assign rep_pos    = !repeats_left[8] && (repeats_left != 9'sd0);
  assign rep_dec    = repeats_left - 9'sd1;
  assign in_range   = (cur_w < rl_w) && (cur_w >= rf_w);
  assign frame_fwd  = place(cur_w + dir_w, eff_count);
  assign fa_w       = $signed({{(SW-FW){1'b0}}, frame_fwd});
  assign period_sum = {1'b0, period_elapsed} + {1'b0, in_dt};
  assign pause_sum  = {1'b0, pause_elapsed} + {1'b0, in_dt};

  always_comb begin
    current_frame_next   = current_frame;
    active_next          = active;
    reverse_pending_next = reverse_pending;
    reversing_next       = reversing;
    repeats_left_next    = repeats_left;
    range_offset_next    = range_offset;
    period_elapsed_next  = period_elapsed;
    pause_elapsed_next   = pause_elapsed;
    delay_left_next      = delay_left;
    end_flag             = 1'b0;
    cyc_flag             = 1'b0;
    hold                 = 1'b0;
    unique case (in_op)
      OP_START: begin
        range_offset_next    = '0;
        period_elapsed_next  = '0;
        pause_elapsed_next   = '0;
        active_next          = 1'b1;
        repeats_left_next    = repeat_init;
        reverse_pending_next = reverse_needed;
        reversing_next       = 1'b0;
        delay_left_next      = $signed({1'b0, start_delay});
        if (!sheet) begin
          current_frame_next = place(rf_w, eff_count);
        end
      end
      OP_STOP: begin
        current_frame_next = '0;
        active_next        = 1'b0;
      end
      OP_TICK: begin
        if (in_vis) begin
          if (!delay_left[TIME_BITS]) begin
            delay_left_next = delay_left - $signed({1'b0, in_dt});
          end else if (active && (repeats_left != 9'sd0)) begin
            if (period_sum >= {1'b0, frame_period}) begin
              period_elapsed_next = '0;
              if (sheet) begin
                if (reversing && (current_frame == '0)) begin
                  active_next    = 1'b0;
                  reversing_next = 1'b0;
                  end_flag       = 1'b1;
                end else begin
                  if (rep_pos && cur_is_last) begin
                    repeats_left_next = rep_dec;
                    if (rep_dec == 9'sd0) begin
                      if (reverse_pending) begin
                        // last forward cycle done: one backward pass follows
                        repeats_left_next    = 9'sd1;
                        reverse_pending_next = 1'b0;
                        reversing_next       = 1'b1;
                        current_frame_next   = place(back_w, eff_count);
                        hold                 = 1'b1;
                      end else begin
                        active_next = 1'b0;
                        end_flag    = 1'b1;
                      end
                    end
                  end
                  if (!hold && cur_is_last) begin
                    cyc_flag = 1'b1;
                    if (cycle_pause != '0) begin
                      if (pause_sum < {1'b0, cycle_pause}) begin
                        pause_elapsed_next = pause_sum[TIME_BITS-1:0];
                        hold               = 1'b1;
                      end else begin
                        pause_elapsed_next = '0;
                      end
                    end
                  end
                  if (!hold) begin
                    current_frame_next = reversing ? place(back_w, eff_count)
                                                   : place(cur_w + one_w, eff_count);
                  end
                end
              end else begin
                if (in_range) begin
                  current_frame_next = frame_fwd;
                  range_offset_next  = range_offset + $signed(dir9);
                  if (reverse_pending && ((fa_w == rl_w) || (fa_w == rf_w))) begin
                    reversing_next = !reversing;
                  end
                end else if (rep_pos) begin
                  repeats_left_next = rep_dec;
                  range_offset_next = '0;
                  if (rep_dec == 9'sd0) begin
                    active_next = 1'b0;
                    end_flag    = 1'b1;
                  end
                end else if (reverse_pending) begin
                  // ping-pong turn at an end of the range
                  reversing_next     = !reversing;
                  current_frame_next = place(rf_w + ro_w + dir_c_w, eff_count);
                  range_offset_next  = range_offset + $signed(dir_c9);
                end else begin
                  current_frame_next = place(rf_w, eff_count);
                  range_offset_next  = '0;
                end
              end
            end else begin
              period_elapsed_next = period_sum[TIME_BITS-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign frame_wide = {8'b0, current_frame_next};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period   <= '0;
      frame_count    <= 9'd1;
      range_first    <= NEG_ONE9;
      range_last     <= NEG_ONE9;
      repeat_init    <= NEG_ONE9;
      reverse_needed <= 1'b0;
      cycle_pause    <= '0;
      start_delay    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_PERIOD:   frame_period   <= cfg_data[TIME_BITS-1:0];
        CFG_FRAME_COUNT:    frame_count    <= cfg_data[8:0];
        CFG_RANGE_FIRST:    range_first    <= cfg_data[8:0];
        CFG_RANGE_LAST:     range_last     <= cfg_data[8:0];
        CFG_REPEAT_INIT:    repeat_init    <= cfg_data[8:0];
        CFG_REVERSE_NEEDED: reverse_needed <= cfg_data[0];
        CFG_CYCLE_PAUSE:    cycle_pause    <= cfg_data[TIME_BITS-1:0];
        CFG_START_DELAY:    start_delay    <= cfg_data[TIME_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame state, updated as an item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_frame   <= '0;
      active          <= 1'b0;
      repeats_left    <= NEG_ONE9;
      reverse_pending <= 1'b0;
      reversing       <= 1'b0;
      period_elapsed  <= '0;
      pause_elapsed   <= '0;
      range_offset    <= '0;
      delay_left      <= '0;
    end else if (advance) begin
      current_frame   <= current_frame_next;
      active          <= active_next;
      repeats_left    <= repeats_left_next;
      reverse_pending <= reverse_pending_next;
      reversing       <= reversing_next;
      period_elapsed  <= period_elapsed_next;
      pause_elapsed   <= pause_elapsed_next;
      range_offset    <= range_offset_next;
      delay_left      <= delay_left_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_dt  <= s_tdata[TIME_BITS-1:0];
      in_vis <= s_tdata[TIME_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.frame_index   <= frame_wide[7:0];
      res.running       <= active_next;
      res.animation_end <= end_flag;
      res.cycle_end     <= cyc_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, res.cycle_end, res.running, res.frame_index};
  assign m_tlast  = res.animation_end;

`include "assert_macros.svh"

  `AST_HOLDS(a_end_not_running, out_valid && res.animation_end |-> !res.running,
             "end beat still running")
  `AST_NEXT(a_stop_result, advance && (in_op == OP_STOP),
            out_valid && (res.frame_index == '0) && !res.running, "stop did not park frame")
  `AST_HOLDS(a_start_activates, $rose(active) |-> $past(advance && (in_op == OP_START)),
             "active rose without start")

endmodule

`default_nettype wire

// ===== tb/sfas_checker.sv =====
// ----------------------------------------------------------------------------
// sfas_checker
// watches the input, result and configuration ports of the sprite sequencer,
// keeps its own copy of the frame state, predicts one result per input beat
// and compares every result beat field by field with the oldest prediction
// ----------------------------------------------------------------------------

module sfas_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // delta_time, visible
  input  logic [1:0]                     s_tuser,   // operation
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [15:0]                    m_tdata,   // frame_index, running, cycle_end
  input  logic                           m_tlast,   // animation_end
  input  logic                           cfg_we,
  input  logic [sfas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                    cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sfas_pkg::*;

  localparam int FRAMES_MAX = 256;

  // configuration copy
  logic [23:0]        per_len;
  logic [8:0]         sheet_frames;
  logic signed [8:0]  rng_first;
  logic signed [8:0]  rng_last;
  logic signed [8:0]  rep_init;
  logic               rev_enable;
  logic [23:0]        pause_len;
  logic [23:0]        delay_init;

  // frame state copy
  logic [7:0]         cur_frame;
  logic               running_st;
  logic signed [8:0]  reps_left;
  logic               rev_pending;
  logic               rev_active;
  logic [23:0]        per_acc;
  logic [23:0]        pause_acc;
  logic signed [8:0]  rng_offset;
  logic signed [24:0] delay_cnt;

  result_t frames_due[$];

  function automatic int frames_eff();
    if (sheet_frames == 0) return 1;
    if (sheet_frames > FRAMES_MAX) return FRAMES_MAX;
    return int'(sheet_frames);
  endfunction

  // anything outside the sheet lands on frame 0
  function automatic void set_frame(int v);
    cur_frame = (v >= 0 && v < frames_eff()) ? 8'(v) : 8'd0;
  endfunction

  function automatic result_t advance_frames(logic [1:0] op, logic [23:0] dt, logic vis);
    result_t     res;
    logic        sheet;
    logic        ended;
    logic        wrapped;
    logic        held;
    int          lastf;
    int          c;
    int          d;
    logic [24:0] acc;
    sheet   = (rng_first == NEG_ONE9) && (rng_last == NEG_ONE9);
    ended   = 1'b0;
    wrapped = 1'b0;
    held    = 1'b0;
    if (op == OP_START) begin
      rng_offset  = '0;
      per_acc     = '0;
      pause_acc   = '0;
      running_st  = 1'b1;
      reps_left   = rep_init;
      rev_pending = rev_enable;
      rev_active  = 1'b0;
      delay_cnt   = $signed({1'b0, delay_init});
      if (!sheet) set_frame(rng_first);
    end else if (op == OP_STOP) begin
      cur_frame  = '0;
      running_st = 1'b0;
    end else if (op == OP_TICK && vis) begin
      c = int'(cur_frame);
      if (delay_cnt >= 0) begin
        // start delay still counting, even a zero delay eats one tick
        delay_cnt = delay_cnt - $signed({1'b0, dt});
      end else if (running_st && reps_left != 0) begin
        acc = {1'b0, per_acc} + {1'b0, dt};
        if (acc < {1'b0, per_len}) begin
          per_acc = acc[23:0];
        end else if (sheet) begin
          per_acc = '0;
          lastf   = frames_eff() - 1;
          if (rev_active && c == 0) begin
            running_st = 1'b0;
            rev_active = 1'b0;
            ended      = 1'b1;
          end else begin
            if (reps_left > 0 && c == lastf) begin
              reps_left = reps_left - 1;
              if (reps_left == 0) begin
                if (rev_pending) begin
                  // last cycle done, turn around for the backward pass
                  reps_left   = 9'sd1;
                  rev_pending = 1'b0;
                  rev_active  = 1'b1;
                  set_frame(c > 1 ? c - 1 : 0);
                  held = 1'b1;
                end else begin
                  running_st = 1'b0;
                  ended      = 1'b1;
                end
              end
            end
            if (!held && c == lastf) begin
              wrapped = 1'b1;
              if (pause_len != 0) begin
                acc = {1'b0, pause_acc} + {1'b0, dt};
                if (acc < {1'b0, pause_len}) begin
                  pause_acc = acc[23:0];
                  held      = 1'b1;
                end else begin
                  pause_acc = '0;
                end
              end
            end
            if (!held) set_frame(rev_active ? (c > 1 ? c - 1 : 0) : c + 1);
          end
        end else begin
          per_acc = '0;
          if (c < rng_last && c >= rng_first) begin
            d = rev_active ? -1 : 1;
            set_frame(c + d);
            rng_offset = 9'(rng_offset + d);
            if (rev_pending && (int'(cur_frame) == rng_last || int'(cur_frame) == rng_first))
              rev_active = !rev_active;
          end else if (reps_left > 0) begin
            // repeat used up but the frame stays where it is
            reps_left  = reps_left - 1;
            rng_offset = '0;
            if (reps_left == 0) begin
              running_st = 1'b0;
              ended      = 1'b1;
            end
          end else if (rev_pending) begin
            rev_active = !rev_active;
            d = rev_active ? -1 : 1;
            set_frame(rng_first + rng_offset + d);
            rng_offset = 9'(rng_offset + d);
          end else begin
            set_frame(rng_first);
            rng_offset = '0;
          end
        end
      end
    end
    res.frame_index   = cur_frame;
    res.running       = running_st;
    res.animation_end = ended;
    res.cycle_end     = wrapped;
    return res;
  endfunction

  task automatic report_field(string fname, int want_v, int got_v);
    $display("%0t mismatch %s expected %0d actual %0d", $time, fname, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      per_len      = '0;
      sheet_frames = 9'd1;
      rng_first    = NEG_ONE9;
      rng_last     = NEG_ONE9;
      rep_init     = NEG_ONE9;
      rev_enable   = 1'b0;
      pause_len    = '0;
      delay_init   = '0;
      cur_frame    = '0;
      running_st   = 1'b0;
      reps_left    = NEG_ONE9;
      rev_pending  = 1'b0;
      rev_active   = 1'b0;
      per_acc      = '0;
      pause_acc    = '0;
      rng_offset   = '0;
      delay_cnt    = '0;
      frames_due.delete();
      errors       = 0;
    end else begin
      // results first: a beat leaving now never belongs to a beat entering now
      if (m_tvalid && m_tready) begin
        got.frame_index   = m_tdata[7:0];
        got.running       = m_tdata[8];
        got.cycle_end     = m_tdata[9];
        got.animation_end = m_tlast;
        if (frames_due.size() == 0) begin
          $display("%0t unexpected result beat expected none actual frame %0d",
                   $time, got.frame_index);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (got.frame_index !== want.frame_index)
            report_field("frame_index", want.frame_index, got.frame_index);
          if (got.running !== want.running)
            report_field("running", want.running, got.running);
          if (got.animation_end !== want.animation_end)
            report_field("animation_end", want.animation_end, got.animation_end);
          if (got.cycle_end !== want.cycle_end)
            report_field("cycle_end", want.cycle_end, got.cycle_end);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_PERIOD:   per_len      = cfg_data;
          CFG_FRAME_COUNT:    sheet_frames = cfg_data[8:0];
          CFG_RANGE_FIRST:    rng_first    = cfg_data[8:0];
          CFG_RANGE_LAST:     rng_last     = cfg_data[8:0];
          CFG_REPEAT_INIT:    rep_init     = cfg_data[8:0];
          CFG_REVERSE_NEEDED: rev_enable   = cfg_data[0];
          CFG_CYCLE_PAUSE:    pause_len    = cfg_data;
          CFG_START_DELAY:    delay_init   = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        frames_due.push_back(advance_frames(s_tuser, s_tdata[23:0], s_tdata[24]));
    end
    pending = frames_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the sprite sequencer with directed and random start, stop, tick and
// unused-operation beats under several register settings, with random gaps on
// both streams, two long result back-pressure stretches and drains between
// settings; the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfas_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [23:0] DT_MAX    = 24'hFF_FFFF;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata   = '0;   // delta_time, visible
  logic [1:0]           s_tuser   = '0;   // operation
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;          // frame_index, running, cycle_end
  logic                 m_tlast;          // animation_end
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0]          cfg_data  = '0;

  int          errors;
  int          pending;
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  logic [23:0] phase_period = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sprite_frame_animation_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfas_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // mostly around the frame period so frames actually step
  function automatic logic [23:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DT_MAX;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(0, 2 * phase_period + 2));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(logic [1:0] op, logic [23:0] dt, logic vis);
    if (!quiet && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, vis, dt};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_config(logic [23:0] period, logic [8:0] count, logic [8:0] first,
                              logic [8:0] last, logic [8:0] rep, logic rev,
                              logic [23:0] pause, logic [23:0] delay);
    logic [23:0] vals [0:7];
    vals[CFG_FRAME_PERIOD]   = period;
    vals[CFG_FRAME_COUNT]    = {15'b0, count};
    vals[CFG_RANGE_FIRST]    = {15'b0, first};
    vals[CFG_RANGE_LAST]     = {15'b0, last};
    vals[CFG_REPEAT_INIT]    = {15'b0, rep};
    vals[CFG_REVERSE_NEEDED] = {23'b0, rev};
    vals[CFG_CYCLE_PAUSE]    = pause;
    vals[CFG_START_DELAY]    = delay;
    phase_period = period;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end
      m_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int          ph;
    int          n;
    int          r;
    logic [8:0]  fc;
    logic [8:0]  rf;
    logic [8:0]  rl;
    logic [8:0]  rp;
    logic [23:0] pd;
    logic [23:0] pz;
    logic [23:0] dz;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // full sheet: walk, pause at the last frame, repeat, backward pass, end
    write_config(24'h10, 9'd4, NEG_ONE9, NEG_ONE9, 9'd2, 1'b1, 24'h20, 24'd0);
    send_beat(OP_START, 24'd0, 1'b1);
    send_beat(OP_TICK, 24'd1, 1'b1);
    send_beat(OP_TICK, DT_MAX, 1'b0);
    for (n = 0; n < 8; n++) send_beat(OP_TICK, 24'h10, 1'b1);
    send_beat(OP_UNUSED, DT_MAX, 1'b1);
    send_beat(OP_STOP, 24'd0, 1'b0);
    send_beat(OP_TICK, DT_MAX, 1'b1);

    // range mode with ping-pong after a start delay
    drain();
    write_config(24'd0, 9'd6, 9'd2, 9'd5, NEG_ONE9, 1'b1, 24'd0, 24'd5);
    send_beat(OP_START, 24'd0, 1'b1);
    send_beat(OP_TICK, 24'd3, 1'b1);
    send_beat(OP_TICK, 24'd3, 1'b1);
    for (n = 0; n < 8; n++) send_beat(OP_TICK, 24'd0, 1'b1);
    send_beat(OP_STOP, DT_MAX, 1'b1);

    for (ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 0) begin
        write_config(DT_MAX, 9'h1FF, 9'd255, 9'd255, 9'd255, 1'b1, DT_MAX, DT_MAX);
      end else if (ph == 1) begin
        write_config(24'd0, 9'd0, 9'h100, 9'h100, 9'h100, 1'b0, 24'd0, 24'd0);
      end else begin
        case ($urandom_range(0, 5))
          0:       pd = '0;
          1:       pd = 24'd1;
          4:       pd = DT_MAX;
          5:       pd = 24'($urandom);
          default: pd = 24'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 6))
          0:       fc = 9'd1;
          1:       fc = 9'd2;
          2:       fc = 9'd256;
          6:       fc = 9'($urandom);
          default: fc = 9'($urandom_range(2, 8));
        endcase
        if ($urandom_range(1)) begin
          rf = NEG_ONE9;
          rl = NEG_ONE9;
        end else begin
          rf = 9'($urandom_range(0, 9)) - 9'd1;
          rl = ($urandom_range(9) == 0) ? 9'd255 : 9'($urandom_range(0, 9)) - 9'd1;
        end
        case ($urandom_range(0, 5))
          0:       rp = NEG_ONE9;
          1:       rp = 9'd0;
          4:       rp = 9'd255;
          5:       rp = 9'($urandom);
          default: rp = 9'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 3))
          2:       pz = 24'($urandom_range(1, 60));
          3:       pz = DT_MAX;
          default: pz = '0;
        endcase
        case ($urandom_range(0, 3))
          2:       dz = 24'($urandom_range(1, 60));
          3:       dz = DT_MAX;
          default: dz = '0;
        endcase
        write_config(pd, fc, rf, rl, rp, 1'($urandom_range(1)), pz, dz);
      end
      quiet = (ph == 4);
      // long result hold-off so the block fills and stalls its input
      if (ph == 2 || ph == 7) hold_req = 1'b1;
      send_beat(OP_START, pick_dt(), 1'b1);
      for (n = 0; n < 52; n++) begin
        r = $urandom_range(99);
        if (r < 5)
          send_beat(OP_START, pick_dt(), 1'($urandom_range(1)));
        else if (r < 9)
          send_beat(OP_STOP, pick_dt(), 1'($urandom_range(1)));
        else if (r < 12)
          send_beat(OP_UNUSED, pick_dt(), 1'($urandom_range(1)));
        else
          send_beat(OP_TICK, pick_dt(), $urandom_range(99) >= 10);
      end
      quiet = 1'b0;
    end

    drain();
    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
